### rtl/core/ptd_pkg.sv
// Shared definitions for the periodic task dispatcher.
// Port field widths, operation and status codes, register indexes, the controller
// command set and the status bundle. No dependencies.
package ptd_pkg;

	// port field widths
	localparam int OP_W       = 4;
	localparam int NOW_W      = 32;
	localparam int HNDL_W     = 16;
	localparam int PER_W      = 16;
	localparam int STS_W      = 2;
	localparam int SLOT_W     = 6;
	localparam int CNT_OUT_W  = 7;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam int LIM_W      = 7;
	localparam int IVL_W      = 16;

	// parameter defaults
	localparam int DEF_TABLE_DEPTH  = 64;
	localparam int DEF_HANDLE_WIDTH = 16;
	localparam int DEF_TIME_WIDTH   = 32;

	// operation codes
	localparam logic [OP_W-1:0] OP_TICK        = 4'd0;
	localparam logic [OP_W-1:0] OP_ADD         = 4'd1;
	localparam logic [OP_W-1:0] OP_DELETE      = 4'd2;
	localparam logic [OP_W-1:0] OP_SET_ENABLE  = 4'd3;
	localparam logic [OP_W-1:0] OP_SET_PERIOD  = 4'd4;
	localparam logic [OP_W-1:0] OP_REPLACE     = 4'd5;
	localparam logic [OP_W-1:0] OP_DELETE_ALL  = 4'd6;
	localparam logic [OP_W-1:0] OP_COMPACT     = 4'd7;
	localparam logic [OP_W-1:0] OP_DEDUP       = 4'd8;
	localparam logic [OP_W-1:0] OP_ENABLE_ALL  = 4'd9;
	localparam logic [OP_W-1:0] OP_DISABLE_ALL = 4'd10;

	// result status codes
	localparam logic [STS_W-1:0] STS_OK        = 2'd0;
	localparam logic [STS_W-1:0] STS_NOT_FOUND = 2'd1;
	localparam logic [STS_W-1:0] STS_FULL      = 2'd2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_SLOT_LIMIT   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_COMPACT_ON   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_COMPACT_IVL  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_DEDUP_ON     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_DEDUP_IVL    = 3'd4;

	// datapath micro-operations issued by the controller
	typedef enum logic [4:0] {
		C_NOP,
		C_LOAD,
		C_A0,
		C_AB0,
		C_INC_A,
		C_RD_A,
		C_RD_B,
		C_CMP_EV,
		C_A_GETS_B,
		C_CLR_A,
		C_SET_CNT_B,
		C_NCMP,
		C_NDDP,
		C_CUR_WRAP,
		C_TK_EV,
		C_DD_I,
		C_DD_J,
		C_NF,
		C_MOD,
		C_ADD,
		C_CLRALL,
		C_EN_EV,
		C_DONE
	} cmd_t;

	// datapath status seen by the controller
	typedef struct packed {
		logic [OP_W-1:0] op;
		logic            a_lt_n;
		logic            b_lt_n;
		logic            a_lt_lim;
		logic            cnt_zero;
		logic            cmp_go;
		logic            dd_go;
		logic            row_nz;
		logic            hit;
		logic            out_busy;
	} dp_stat_t;

endpackage

### rtl/core/ptd_if.sv
// Request and response channel interfaces of the periodic task dispatcher.
// Depends on ptd_pkg for the field widths.
interface ptd_req_if;
	logic                         valid;
	logic                         ready;
	logic [ptd_pkg::OP_W-1:0]     operation;
	logic [ptd_pkg::NOW_W-1:0]    now_ms;
	logic [ptd_pkg::HNDL_W-1:0]   task_handle;
	logic [ptd_pkg::HNDL_W-1:0]   new_handle;
	logic [ptd_pkg::PER_W-1:0]    period_ms;
	logic                         run_enable;

	modport source (output valid, operation, now_ms, task_handle, new_handle, period_ms,
		run_enable, input ready);
	modport sink (input valid, operation, now_ms, task_handle, new_handle, period_ms,
		run_enable, output ready);
endinterface

interface ptd_rsp_if;
	logic                           valid;
	logic                           ready;
	logic [ptd_pkg::STS_W-1:0]      status;
	logic                           dispatch_valid;
	logic [ptd_pkg::HNDL_W-1:0]     dispatched_handle;
	logic [ptd_pkg::SLOT_W-1:0]     slot_index;
	logic [ptd_pkg::CNT_OUT_W-1:0]  task_count;

	modport source (output valid, status, dispatch_valid, dispatched_handle, slot_index,
		task_count, input ready);
	modport sink (input valid, status, dispatch_valid, dispatched_handle, slot_index,
		task_count, output ready);
endinterface

### rtl/core/ptd_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ptd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

### rtl/core/ptd_dp.sv
// Datapath of the periodic task dispatcher: slot table memory, row valid bits,
// counters, time registers, configuration and the response register. Uses ptd_pkg, ptd_ram.
module ptd_dp #(
	parameter int TABLE_DEPTH  = ptd_pkg::DEF_TABLE_DEPTH,
	parameter int HANDLE_WIDTH = ptd_pkg::DEF_HANDLE_WIDTH,
	parameter int TIME_WIDTH   = ptd_pkg::DEF_TIME_WIDTH
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  ptd_pkg::cmd_t                   cmd,
	output ptd_pkg::dp_stat_t               stat,
	input  logic                            cfg_we,
	input  logic [ptd_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  logic [ptd_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	input  logic [ptd_pkg::OP_W-1:0]        operation,
	input  logic [ptd_pkg::NOW_W-1:0]       now_ms,
	input  logic [ptd_pkg::HNDL_W-1:0]      task_handle,
	input  logic [ptd_pkg::HNDL_W-1:0]      new_handle,
	input  logic [ptd_pkg::PER_W-1:0]       period_ms,
	input  logic                            run_enable,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [ptd_pkg::STS_W-1:0]       out_status,
	output logic                            out_dispatch_valid,
	output logic [ptd_pkg::HNDL_W-1:0]      out_dispatched_handle,
	output logic [ptd_pkg::SLOT_W-1:0]      out_slot_index,
	output logic [ptd_pkg::CNT_OUT_W-1:0]   out_task_count
);
	import ptd_pkg::*;

	localparam int IW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int LW = (CW > LIM_W) ? CW : LIM_W;
	localparam int RW = HANDLE_WIDTH + PER_W + TIME_WIDTH + 1;
	localparam logic [LIM_W-1:0] LIM_RST = (TABLE_DEPTH > 127) ? 7'd127 : LIM_W'(TABLE_DEPTH);

	// control registers
	logic [CW-1:0]         count_q, a_q, b_q;
	logic [IW-1:0]         cursor_q;
	logic                  skip_q;
	logic [TIME_WIDTH-1:0] ncmp_q, nddp_q;
	logic [TABLE_DEPTH-1:0] vld_q;
	logic [LIM_W-1:0]      lim_q;
	logic                  cmp_on_q, dd_on_q;
	logic [IVL_W-1:0]      cmp_ivl_q, dd_ivl_q;
	logic                  out_vld_q;

	// item and working registers
	logic [OP_W-1:0]         op_q;
	logic [TIME_WIDTH-1:0]   now_q;
	logic [HANDLE_WIDTH-1:0] th_q, nh_q, refh_q;
	logic [PER_W-1:0]        per_q;
	logic                    en_q;
	logic                    vld_s1;
	logic [STS_W-1:0]        res_sts_q;
	logic                    res_dv_q;
	logic [HANDLE_WIDTH-1:0] res_dh_q;
	logic [IW-1:0]           res_slot_q;

	// memory ports
	logic          ram_we, ram_re;
	logic [IW-1:0] ram_waddr, ram_raddr;
	logic [RW-1:0] ram_wdata, ram_rdata;

	ptd_ram #(.WIDTH(RW), .DEPTH(TABLE_DEPTH)) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// row fields; a never-written row reads as empty
	logic [HANDLE_WIDTH-1:0] row_h;
	logic [PER_W-1:0]        row_p;
	logic [TIME_WIDTH-1:0]   row_d;
	logic                    row_e;
	always_comb begin
		row_h = vld_s1 ? ram_rdata[RW-1 -: HANDLE_WIDTH] : '0;
		row_p = vld_s1 ? ram_rdata[TIME_WIDTH+1 +: PER_W] : '0;
		row_d = vld_s1 ? ram_rdata[1 +: TIME_WIDTH] : '0;
		row_e = vld_s1 ? ram_rdata[0] : 1'b0;
	end

	// derived conditions
	logic [CW-1:0]         eff_lim;
	logic                  row_nz, full, due_hit;
	logic [TIME_WIDTH-1:0] now_row_sum, now_per_sum;
	logic [CW-1:0]         a_inc;
	always_comb begin
		eff_lim     = (LW'(lim_q) > LW'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH) : CW'(lim_q);
		row_nz      = (row_h != '0);
		full        = (count_q >= eff_lim);
		due_hit     = row_nz && row_e && (now_q >= row_d);
		now_row_sum = now_q + TIME_WIDTH'(row_p);
		now_per_sum = now_q + TIME_WIDTH'(per_q);
		a_inc       = a_q + CW'(1);
	end

	// status to the controller
	always_comb begin
		stat.op       = op_q;
		stat.a_lt_n   = (a_q < count_q);
		stat.b_lt_n   = (b_q < count_q);
		stat.a_lt_lim = (a_q < eff_lim);
		stat.cnt_zero = (count_q == '0);
		stat.cmp_go   = cmp_on_q && (now_q >= ncmp_q);
		stat.dd_go    = dd_on_q && (now_q >= nddp_q);
		stat.row_nz   = row_nz;
		stat.hit      = (row_h == th_q);
		stat.out_busy = out_vld_q && !out_ready;
	end

	// memory read and write control
	always_comb begin
		ram_re    = (cmd == C_RD_A) || (cmd == C_RD_B);
		ram_raddr = (cmd == C_RD_B) ? b_q[IW-1:0] : a_q[IW-1:0];
		ram_we    = 1'b0;
		ram_waddr = a_q[IW-1:0];
		ram_wdata = {row_h, row_p, row_d, row_e};
		case (cmd)
			C_CMP_EV: begin
				ram_we    = row_nz;
				ram_waddr = b_q[IW-1:0];
			end
			C_TK_EV: begin
				ram_we    = due_hit && !skip_q;
				ram_wdata = {row_h, row_p, now_row_sum, row_e};
			end
			C_DD_J: begin
				ram_we    = (row_h == refh_q);
				ram_waddr = b_q[IW-1:0];
				ram_wdata = {{HANDLE_WIDTH{1'b0}}, row_p, row_d, row_e};
			end
			C_MOD: begin
				ram_we = 1'b1;
				case (op_q)
					OP_DELETE:     ram_wdata = {{HANDLE_WIDTH{1'b0}}, row_p, row_d, row_e};
					OP_SET_ENABLE: ram_wdata = {row_h, row_p, row_d, en_q};
					OP_SET_PERIOD: ram_wdata = {row_h, per_q, now_per_sum, row_e};
					default:       ram_wdata = {nh_q, per_q, now_per_sum, en_q};
				endcase
			end
			C_ADD: begin
				ram_we    = !full;
				ram_waddr = count_q[IW-1:0];
				ram_wdata = {th_q, per_q, {TIME_WIDTH{1'b0}}, en_q};
			end
			C_EN_EV: begin
				ram_we    = 1'b1;
				ram_wdata = {row_h, row_p, row_d, (op_q == OP_ENABLE_ALL)};
			end
			default: ;
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			a_q       <= '0;
			b_q       <= '0;
			cursor_q  <= '0;
			skip_q    <= 1'b0;
			ncmp_q    <= '0;
			nddp_q    <= '0;
			vld_q     <= '0;
			lim_q     <= LIM_RST;
			cmp_on_q  <= 1'b0;
			dd_on_q   <= 1'b0;
			cmp_ivl_q <= IVL_W'(1000);
			dd_ivl_q  <= IVL_W'(1000);
			out_vld_q <= 1'b0;
		end else begin
			if (ram_we) begin
				vld_q[ram_waddr] <= 1'b1;
			end
			case (cmd)
				C_A0:        a_q <= '0;
				C_AB0: begin
					a_q <= '0;
					b_q <= '0;
				end
				C_INC_A:     a_q <= a_inc;
				C_CMP_EV: begin
					a_q <= a_inc;
					if (row_nz) begin
						b_q <= b_q + CW'(1);
					end
				end
				C_A_GETS_B:  a_q <= b_q;
				C_CLR_A: begin
					vld_q[a_q[IW-1:0]] <= 1'b0;
					a_q <= a_inc;
				end
				C_SET_CNT_B: count_q <= b_q;
				C_NCMP:      ncmp_q <= now_q + TIME_WIDTH'(cmp_ivl_q);
				C_NDDP:      nddp_q <= now_q + TIME_WIDTH'(dd_ivl_q);
				C_CUR_WRAP:  a_q <= (CW'(cursor_q) >= count_q) ? '0 : CW'(cursor_q);
				C_TK_EV: begin
					if (due_hit && skip_q) begin
						skip_q <= 1'b0;
					end
					cursor_q <= (a_inc >= count_q) ? '0 : a_inc[IW-1:0];
				end
				C_DD_I: begin
					b_q <= a_inc;
					if (!row_nz) begin
						a_q <= a_inc;
					end
				end
				C_DD_J:      b_q <= b_q + CW'(1);
				C_NF, C_MOD: begin
					if (op_q == OP_DELETE) begin
						skip_q <= 1'b1;
					end
				end
				C_ADD: begin
					if (!full) begin
						count_q <= count_q + CW'(1);
					end
				end
				C_CLRALL: begin
					vld_q   <= '0;
					count_q <= '0;
					skip_q  <= 1'b1;
				end
				C_EN_EV:     a_q <= a_inc;
				default: ;
			endcase
			// response valid
			if (cmd == C_DONE) begin
				out_vld_q <= 1'b1;
			end else if (out_ready) begin
				out_vld_q <= 1'b0;
			end
			// configuration writes
			if (cfg_we) begin
				unique case (cfg_idx)
					CFG_SLOT_LIMIT:  lim_q     <= cfg_wdata[LIM_W-1:0];
					CFG_COMPACT_ON:  cmp_on_q  <= cfg_wdata[0];
					CFG_COMPACT_IVL: cmp_ivl_q <= cfg_wdata[IVL_W-1:0];
					CFG_DEDUP_ON:    dd_on_q   <= cfg_wdata[0];
					CFG_DEDUP_IVL:   dd_ivl_q  <= cfg_wdata[IVL_W-1:0];
					default: ;
				endcase
			end
		end
	end

	// item, result and response payload
	always_ff @(posedge clk) begin
		if (ram_re) begin
			vld_s1 <= vld_q[ram_raddr];
		end
		case (cmd)
			C_LOAD: begin
				op_q       <= operation;
				now_q      <= TIME_WIDTH'(now_ms);
				th_q       <= HANDLE_WIDTH'(task_handle);
				nh_q       <= HANDLE_WIDTH'(new_handle);
				per_q      <= period_ms;
				en_q       <= run_enable;
				res_sts_q  <= STS_OK;
				res_dv_q   <= 1'b0;
				res_dh_q   <= '0;
				res_slot_q <= '0;
			end
			C_TK_EV: begin
				res_slot_q <= a_q[IW-1:0];
				if (due_hit) begin
					res_dv_q <= 1'b1;
					res_dh_q <= row_h;
				end
			end
			C_DD_I: refh_q <= row_h;
			C_NF:   res_sts_q <= STS_NOT_FOUND;
			C_MOD:  res_slot_q <= a_q[IW-1:0];
			C_ADD: begin
				if (full) begin
					res_sts_q <= STS_FULL;
				end else begin
					res_slot_q <= count_q[IW-1:0];
				end
			end
			C_DONE: begin
				out_status            <= res_sts_q;
				out_dispatch_valid    <= res_dv_q;
				out_dispatched_handle <= HNDL_W'(res_dh_q);
				out_slot_index        <= SLOT_W'(res_slot_q);
				out_task_count        <= CNT_OUT_W'(count_q);
			end
			default: ;
		endcase
	end

	assign out_valid = out_vld_q;
endmodule

### rtl/core/ptd_ctrl.sv
// Controller state machine of the periodic task dispatcher: sequences table walks
// and issues one datapath micro-operation per cycle. Uses ptd_pkg.
module ptd_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  ptd_pkg::dp_stat_t stat,
	output ptd_pkg::cmd_t     cmd
);
	import ptd_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE,
		S_DEC,
		S_TK1,
		S_TK2,
		S_TK3,
		S_TK_RD,
		S_TK_EV,
		S_CP_START,
		S_CP_LOOP,
		S_CP_EV,
		S_CP_CLR,
		S_DD_START,
		S_DD_I,
		S_DD_IEV,
		S_DD_J,
		S_DD_JEV,
		S_F_LOOP,
		S_F_EV,
		S_E_LOOP,
		S_E_EV,
		S_FIN
	} state_t;

	state_t state_q, nxt;
	logic   is_tick;

	assign is_tick   = (stat.op == OP_TICK);
	assign req_ready = (state_q == S_IDLE);

	// next state and command decode
	always_comb begin
		nxt = state_q;
		cmd = C_NOP;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd = C_LOAD;
					nxt = S_DEC;
				end
			end
			S_DEC: begin
				unique case (stat.op) inside
					OP_TICK: nxt = S_TK1;
					OP_ADD: begin
						cmd = C_ADD;
						nxt = S_FIN;
					end
					OP_DELETE, OP_SET_ENABLE, OP_SET_PERIOD, OP_REPLACE: begin
						cmd = C_A0;
						nxt = S_F_LOOP;
					end
					OP_DELETE_ALL: begin
						cmd = C_CLRALL;
						nxt = S_FIN;
					end
					OP_COMPACT: nxt = S_CP_START;
					OP_DEDUP:   nxt = S_DD_START;
					OP_ENABLE_ALL, OP_DISABLE_ALL: begin
						cmd = C_A0;
						nxt = S_E_LOOP;
					end
					default: nxt = S_FIN;
				endcase
			end
			// tick: optional compaction, optional dedup, then the cursor slot
			S_TK1: begin
				if (stat.cmp_go) begin
					cmd = C_NCMP;
					nxt = S_CP_START;
				end else begin
					nxt = S_TK2;
				end
			end
			S_TK2: begin
				if (stat.dd_go) begin
					cmd = C_NDDP;
					nxt = S_DD_START;
				end else begin
					nxt = S_TK3;
				end
			end
			S_TK3: begin
				if (stat.cnt_zero) begin
					nxt = S_FIN;
				end else begin
					cmd = C_CUR_WRAP;
					nxt = S_TK_RD;
				end
			end
			S_TK_RD: begin
				cmd = C_RD_A;
				nxt = S_TK_EV;
			end
			S_TK_EV: begin
				cmd = C_TK_EV;
				nxt = S_FIN;
			end
			// compaction: copy occupied rows forward, then drop the tail
			S_CP_START: begin
				cmd = C_AB0;
				nxt = S_CP_LOOP;
			end
			S_CP_LOOP: begin
				if (stat.a_lt_n) begin
					cmd = C_RD_A;
					nxt = S_CP_EV;
				end else begin
					cmd = C_A_GETS_B;
					nxt = S_CP_CLR;
				end
			end
			S_CP_EV: begin
				cmd = C_CMP_EV;
				nxt = S_CP_LOOP;
			end
			S_CP_CLR: begin
				if (stat.a_lt_n) begin
					cmd = C_CLR_A;
				end else begin
					cmd = C_SET_CNT_B;
					nxt = is_tick ? S_TK2 : S_FIN;
				end
			end
			// dedup: for each occupied row, empty later rows with the same handle
			S_DD_START: begin
				cmd = C_A0;
				nxt = S_DD_I;
			end
			S_DD_I: begin
				if (stat.a_lt_n) begin
					cmd = C_RD_A;
					nxt = S_DD_IEV;
				end else begin
					nxt = is_tick ? S_TK3 : S_FIN;
				end
			end
			S_DD_IEV: begin
				cmd = C_DD_I;
				nxt = stat.row_nz ? S_DD_J : S_DD_I;
			end
			S_DD_J: begin
				if (stat.b_lt_n) begin
					cmd = C_RD_B;
					nxt = S_DD_JEV;
				end else begin
					cmd = C_INC_A;
					nxt = S_DD_I;
				end
			end
			S_DD_JEV: begin
				cmd = C_DD_J;
				nxt = S_DD_J;
			end
			// handle search with in-place update on a hit
			S_F_LOOP: begin
				if (stat.a_lt_n) begin
					cmd = C_RD_A;
					nxt = S_F_EV;
				end else begin
					cmd = C_NF;
					nxt = S_FIN;
				end
			end
			S_F_EV: begin
				if (stat.hit) begin
					cmd = C_MOD;
					nxt = S_FIN;
				end else begin
					cmd = C_INC_A;
					nxt = S_F_LOOP;
				end
			end
			// enable or disable every slot below the limit
			S_E_LOOP: begin
				if (stat.a_lt_lim) begin
					cmd = C_RD_A;
					nxt = S_E_EV;
				end else begin
					nxt = S_FIN;
				end
			end
			S_E_EV: begin
				cmd = C_EN_EV;
				nxt = S_E_LOOP;
			end
			// hand the result to the response register
			S_FIN: begin
				if (!stat.out_busy) begin
					cmd = C_DONE;
					nxt = S_IDLE;
				end
			end
			default: nxt = S_IDLE;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= nxt;
		end
	end
endmodule

### rtl/core/periodic_task_dispatcher.sv
// Top level of the periodic task dispatcher: request and response channels,
// configuration write port. Uses ptd_pkg, ptd_if, ptd_ctrl, ptd_dp.
//
// A table of TABLE_DEPTH task slots sits in a RAM with one write port and one
// registered read port; every slot visit is a read, then an evaluate and write
// back. One request is worked on at a time and gives one response. A tick may
// run automatic compaction and automatic duplicate removal before it visits the
// cursor slot; a handle search scans the slots in use until a hit, and enable or
// disable all visits every slot below the limit.
// The response sits in an output register, so the next request is taken while
// an earlier response waits; a request finishing into a still-full response
// register holds until it is taken. The user must see that configuration is
// written only while idle; the block itself does not enforce this.
module periodic_task_dispatcher #(
	parameter int TABLE_DEPTH  = ptd_pkg::DEF_TABLE_DEPTH,
	parameter int HANDLE_WIDTH = ptd_pkg::DEF_HANDLE_WIDTH,
	parameter int TIME_WIDTH   = ptd_pkg::DEF_TIME_WIDTH
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [ptd_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [ptd_pkg::CFG_DATA_W-1:0] cfg_wdata,
	ptd_req_if.sink                        req,
	ptd_rsp_if.source                      rsp
);
	import ptd_pkg::*;

	cmd_t     cmd;
	dp_stat_t stat;
	logic     ready;

	assign req.ready = ready;

	// sequencing
	ptd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// table, registers and response
	ptd_dp #(
		.TABLE_DEPTH  (TABLE_DEPTH),
		.HANDLE_WIDTH (HANDLE_WIDTH),
		.TIME_WIDTH   (TIME_WIDTH)
	) u_dp (
		.clk                   (clk),
		.arst_n                (arst_n),
		.cmd                   (cmd),
		.stat                  (stat),
		.cfg_we                (cfg_we),
		.cfg_idx               (cfg_idx),
		.cfg_wdata             (cfg_wdata),
		.operation             (req.operation),
		.now_ms                (req.now_ms),
		.task_handle           (req.task_handle),
		.new_handle            (req.new_handle),
		.period_ms             (req.period_ms),
		.run_enable            (req.run_enable),
		.out_valid             (rsp.valid),
		.out_ready             (rsp.ready),
		.out_status            (rsp.status),
		.out_dispatch_valid    (rsp.dispatch_valid),
		.out_dispatched_handle (rsp.dispatched_handle),
		.out_slot_index        (rsp.slot_index),
		.out_task_count        (rsp.task_count)
	);
endmodule

### bench/testbench.sv
// Self-checking bench for the periodic task dispatcher: random and directed requests
// against a behavioral table model. Uses ptd_pkg, ptd_if and the dispatcher RTL.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import ptd_pkg::*;

	typedef struct packed {
		logic [OP_W-1:0]   operation;
		logic [NOW_W-1:0]  now_ms;
		logic [HNDL_W-1:0] task_handle;
		logic [HNDL_W-1:0] new_handle;
		logic [PER_W-1:0]  period_ms;
		logic              run_enable;
	} request_t;

	typedef struct packed {
		logic [STS_W-1:0]     status;
		logic                 dispatch_valid;
		logic [HNDL_W-1:0]    dispatched_handle;
		logic [SLOT_W-1:0]    slot_index;
		logic [CNT_OUT_W-1:0] task_count;
	} response_t;

	localparam int DEPTH = 64;
	localparam int CYCLE_LIMIT = 40000000;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	ptd_req_if req ();
	ptd_rsp_if rsp ();

	periodic_task_dispatcher u_top (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
		.cfg_wdata(cfg_wdata), .req(req.sink), .rsp(rsp.source)
	);

	// predicted table state
	logic [HNDL_W-1:0] tbl_handle [DEPTH];
	logic [PER_W-1:0]  tbl_period [DEPTH];
	logic [NOW_W-1:0]  tbl_due [DEPTH];
	logic              tbl_en [DEPTH];
	int unsigned       occ_count, cursor;
	logic              skip_flag;
	logic [NOW_W-1:0]  compact_due, dedup_due;
	int unsigned       lim_reg;
	logic              compact_on, dedup_on;
	logic [IVL_W-1:0]  compact_ivl, dedup_ivl;

	request_t  pending_reqs[$];
	response_t expected_rsps[$];
	int        errors = 0;
	bit        quiet = 0;
	int        req_gap = 0, rsp_gap = 0;
	longint    cycles = 0;

	function automatic int unsigned eff_limit();
		return lim_reg > DEPTH ? DEPTH : lim_reg;
	endfunction

	function automatic int find_handle(logic [HNDL_W-1:0] h);
		for (int i = 0; i < occ_count; i++)
			if (tbl_handle[i] == h) return i;
		return -1;
	endfunction

	function automatic void compact_table();
		int unsigned w;
		w = 0;
		for (int r = 0; r < occ_count; r++) begin
			if (tbl_handle[r] != 0) begin
				tbl_handle[w] = tbl_handle[r];
				tbl_period[w] = tbl_period[r];
				tbl_due[w] = tbl_due[r];
				tbl_en[w] = tbl_en[r];
				w++;
			end
		end
		for (int r = w; r < occ_count; r++) begin
			tbl_handle[r] = 0; tbl_period[r] = 0; tbl_due[r] = 0; tbl_en[r] = 0;
		end
		occ_count = w;
	endfunction

	function automatic void dedup_table();
		for (int i = 0; i < occ_count; i++) begin
			if (tbl_handle[i] == 0) continue;
			for (int j = i + 1; j < occ_count; j++)
				if (tbl_handle[j] == tbl_handle[i]) tbl_handle[j] = 0;
		end
	endfunction

	function automatic void clear_table();
		for (int i = 0; i < DEPTH; i++) begin
			tbl_handle[i] = 0; tbl_period[i] = 0; tbl_due[i] = 0; tbl_en[i] = 0;
		end
	endfunction

	// computes the response to one accepted request and updates the table model
	function automatic response_t dispatch_predict(request_t r);
		response_t o;
		int s;
		o = '0;
		case (r.operation)
			OP_TICK: begin
				if (compact_on && r.now_ms >= compact_due) begin
					compact_table();
					compact_due = r.now_ms + NOW_W'(compact_ivl);
				end
				if (dedup_on && r.now_ms >= dedup_due) begin
					dedup_table();
					dedup_due = r.now_ms + NOW_W'(dedup_ivl);
				end
				if (occ_count > 0) begin
					if (cursor >= occ_count) cursor = 0;
					o.slot_index = SLOT_W'(cursor);
					if (tbl_handle[cursor] != 0 && tbl_en[cursor] &&
						r.now_ms >= tbl_due[cursor]) begin
						o.dispatch_valid = 1;
						o.dispatched_handle = tbl_handle[cursor];
						if (skip_flag) skip_flag = 0;
						else tbl_due[cursor] = r.now_ms + NOW_W'(tbl_period[cursor]);
					end
					cursor++;
					if (cursor >= occ_count) cursor = 0;
				end
			end
			OP_ADD: begin
				if (occ_count >= eff_limit()) begin
					o.status = STS_FULL;
				end else begin
					o.slot_index = SLOT_W'(occ_count);
					tbl_handle[occ_count] = r.task_handle;
					tbl_period[occ_count] = r.period_ms;
					tbl_due[occ_count] = 0;
					tbl_en[occ_count] = r.run_enable;
					occ_count++;
				end
			end
			OP_DELETE, OP_SET_ENABLE, OP_SET_PERIOD, OP_REPLACE: begin
				s = find_handle(r.task_handle);
				if (r.operation == OP_DELETE) skip_flag = 1;
				if (s < 0) begin
					o.status = STS_NOT_FOUND;
				end else begin
					o.slot_index = SLOT_W'(s);
					if (r.operation == OP_DELETE) begin
						tbl_handle[s] = 0;
					end else if (r.operation == OP_SET_ENABLE) begin
						tbl_en[s] = r.run_enable;
					end else begin
						tbl_period[s] = r.period_ms;
						tbl_due[s] = r.now_ms + NOW_W'(r.period_ms);
						if (r.operation == OP_REPLACE) begin
							tbl_handle[s] = r.new_handle;
							tbl_en[s] = r.run_enable;
						end
					end
				end
			end
			OP_DELETE_ALL: begin
				clear_table();
				occ_count = 0;
				skip_flag = 1;
			end
			OP_COMPACT: compact_table();
			OP_DEDUP: dedup_table();
			OP_ENABLE_ALL, OP_DISABLE_ALL: begin
				for (int i = 0; i < eff_limit(); i++) tbl_en[i] = (r.operation == OP_ENABLE_ALL);
			end
			default: ;
		endcase
		o.task_count = CNT_OUT_W'(occ_count);
		return o;
	endfunction

	// clock
	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req.valid <= 0;
			req.operation <= '0; req.now_ms <= '0; req.task_handle <= '0;
			req.new_handle <= '0; req.period_ms <= '0; req.run_enable <= 0;
		end else begin
			if (req.valid && req.ready)
				expected_rsps.push_back(dispatch_predict({req.operation, req.now_ms,
					req.task_handle, req.new_handle, req.period_ms, req.run_enable}));
			if (!req.valid || req.ready) begin
				if (req_gap > 0) begin
					req_gap <= req_gap - 1;
					req.valid <= 0;
				end else if (pending_reqs.size() > 0) begin
					request_t n;
					n = pending_reqs.pop_front();
					{req.operation, req.now_ms, req.task_handle, req.new_handle,
						req.period_ms, req.run_enable} <= n;
					req.valid <= 1;
					if (!quiet && $urandom_range(0, 7) == 0) req_gap <= $urandom_range(1, 16);
				end else begin
					req.valid <= 0;
				end
			end
		end
	end

	// response monitor with random back-pressure
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp.ready <= 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (expected_rsps.size() == 0) begin
					$error("unexpected response");
					errors++;
				end else begin
					response_t e;
					e = expected_rsps.pop_front();
					if (rsp.status !== e.status) begin
						$error("status exp %0d got %0d", e.status, rsp.status); errors++;
					end
					if (rsp.dispatch_valid !== e.dispatch_valid) begin
						$error("dispatch_valid exp %0d got %0d", e.dispatch_valid,
							rsp.dispatch_valid); errors++;
					end
					if (rsp.dispatched_handle !== e.dispatched_handle) begin
						$error("dispatched_handle exp %0d got %0d", e.dispatched_handle,
							rsp.dispatched_handle); errors++;
					end
					if (rsp.slot_index !== e.slot_index) begin
						$error("slot_index exp %0d got %0d", e.slot_index, rsp.slot_index);
						errors++;
					end
					if (rsp.task_count !== e.task_count) begin
						$error("task_count exp %0d got %0d", e.task_count, rsp.task_count);
						errors++;
					end
				end
			end
			if (rsp_gap > 0) begin
				rsp_gap <= rsp_gap - 1;
				rsp.ready <= 0;
			end else begin
				rsp.ready <= 1;
				if (!quiet && $urandom_range(0, 7) == 0) rsp_gap <= $urandom_range(1, 16);
			end
		end
	end

	// timeout watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	logic [NOW_W-1:0] clock_ms;
	logic [HNDL_W-1:0] handle_pool [8];

	function automatic request_t make_req(logic [OP_W-1:0] op, logic [NOW_W-1:0] t,
		logic [HNDL_W-1:0] th, logic [HNDL_W-1:0] nh, logic [PER_W-1:0] per, logic en);
		request_t r;
		r.operation = op; r.now_ms = t; r.task_handle = th; r.new_handle = nh;
		r.period_ms = per; r.run_enable = en;
		return r;
	endfunction

	// random request mostly drawn from a small pool of handles and a rising clock
	function automatic request_t rand_req();
		request_t r;
		int k;
		k = $urandom_range(0, 99);
		r = make_req(OP_TICK, clock_ms, handle_pool[$urandom_range(0, 7)],
			handle_pool[$urandom_range(0, 7)], PER_W'($urandom_range(0, 40)),
			$urandom_range(0, 5) != 0);
		if ($urandom_range(0, 19) == 0) r.task_handle = HNDL_W'($urandom);
		if ($urandom_range(0, 19) == 0) r.new_handle = HNDL_W'($urandom);
		if ($urandom_range(0, 19) == 0) r.period_ms = PER_W'($urandom);
		if ($urandom_range(0, 29) == 0) r.now_ms = $urandom;
		if (k < 45) r.operation = OP_TICK;
		else if (k < 65) r.operation = OP_ADD;
		else if (k < 73) r.operation = OP_DELETE;
		else if (k < 78) r.operation = OP_SET_ENABLE;
		else if (k < 83) r.operation = OP_SET_PERIOD;
		else if (k < 88) r.operation = OP_REPLACE;
		else if (k < 89) r.operation = OP_DELETE_ALL;
		else if (k < 92) r.operation = OP_COMPACT;
		else if (k < 95) r.operation = OP_DEDUP;
		else if (k < 97) r.operation = OP_ENABLE_ALL;
		else if (k < 99) r.operation = OP_DISABLE_ALL;
		else r.operation = OP_W'($urandom_range(11, 15));
		clock_ms = clock_ms + $urandom_range(0, 12);
		return r;
	endfunction

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1; cfg_idx <= idx; cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 0;
		case (idx)
			CFG_SLOT_LIMIT: lim_reg = val[LIM_W-1:0];
			CFG_COMPACT_ON: compact_on = val[0];
			CFG_COMPACT_IVL: compact_ivl = val;
			CFG_DEDUP_ON: dedup_on = val[0];
			CFG_DEDUP_IVL: dedup_ivl = val;
			default: ;
		endcase
	endtask

	// waits until every queued request has been answered, then lets the block settle
	task automatic drain();
		@(negedge clk);
		while (pending_reqs.size() > 0 || expected_rsps.size() > 0 || req.valid)
			@(negedge clk);
		repeat (20) @(posedge clk);
	endtask

	initial begin
		arst_n = 0;
		cfg_we = 0; cfg_idx = '0; cfg_wdata = '0;
		clear_table();
		occ_count = 0; cursor = 0; skip_flag = 0; compact_due = 0; dedup_due = 0;
		lim_reg = 64; compact_on = 0; compact_ivl = 1000; dedup_on = 0; dedup_ivl = 1000;
		clock_ms = 0;
		for (int i = 0; i < 8; i++)
			handle_pool[i] = (i == 0) ? 16'h0 : HNDL_W'($urandom_range(1, 9));
		handle_pool[7] = 16'hFFFF;
		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: field extremes, every operation, wrap, search for zero
		pending_reqs.push_back(make_req(OP_TICK, 0, 0, 0, 0, 0));
		pending_reqs.push_back(make_req(OP_DELETE, 5, 3, 0, 0, 0));
		pending_reqs.push_back(make_req(OP_ADD, 1, 16'hFFFF, 0, 16'hFFFF, 1));
		pending_reqs.push_back(make_req(OP_ADD, 2, 5, 0, 0, 1));
		pending_reqs.push_back(make_req(OP_ADD, 3, 5, 0, 10, 1));
		pending_reqs.push_back(make_req(OP_ADD, 3, 0, 0, 1, 1));
		pending_reqs.push_back(make_req(OP_TICK, 32'hFFFFFFFF, 0, 0, 0, 0));
		pending_reqs.push_back(make_req(OP_TICK, 32'hFFFFFFFF, 0, 0, 0, 0));
		pending_reqs.push_back(make_req(OP_DELETE, 4, 5, 0, 0, 0));
		pending_reqs.push_back(make_req(OP_TICK, 10, 0, 0, 0, 0));
		pending_reqs.push_back(make_req(OP_SET_ENABLE, 10, 16'hFFFF, 0, 0, 0));
		pending_reqs.push_back(make_req(OP_SET_PERIOD, 32'hFFFFFFF0, 16'hFFFF, 0, 16'hFFFF, 1));
		pending_reqs.push_back(make_req(OP_REPLACE, 11, 0, 16'hAAAA, 7, 1));
		pending_reqs.push_back(make_req(OP_REPLACE, 11, 16'h1234, 16'h5555, 7, 1));
		pending_reqs.push_back(make_req(OP_ADD, 12, 16'hAAAA, 0, 3, 0));
		pending_reqs.push_back(make_req(OP_DEDUP, 12, 0, 0, 0, 0));
		pending_reqs.push_back(make_req(OP_COMPACT, 12, 0, 0, 0, 0));
		pending_reqs.push_back(make_req(OP_DISABLE_ALL, 12, 0, 0, 0, 0));
		pending_reqs.push_back(make_req(OP_ENABLE_ALL, 12, 0, 0, 0, 1));
		pending_reqs.push_back(make_req(OP_TICK, 20, 0, 0, 0, 0));
		pending_reqs.push_back(make_req(4'hF, 20, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1));
		pending_reqs.push_back(make_req(OP_DELETE_ALL, 21, 0, 0, 0, 0));
		drain();

		// small limit, full table, limit zero
		write_reg(CFG_SLOT_LIMIT, 3);
		for (int i = 0; i < 5; i++)
			pending_reqs.push_back(make_req(OP_ADD, NOW_W'(i), HNDL_W'(i + 1), 0, 2, 1));
		pending_reqs.push_back(make_req(OP_DISABLE_ALL, 0, 0, 0, 0, 0));
		drain();
		write_reg(CFG_SLOT_LIMIT, 0);
		pending_reqs.push_back(make_req(OP_ADD, 0, 1, 0, 0, 1));
		pending_reqs.push_back(make_req(OP_DELETE_ALL, 0, 0, 0, 0, 0));
		pending_reqs.push_back(make_req(OP_ADD, 0, 1, 0, 0, 1));
		drain();

		// random phases over several settings, last phase with no idling
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: begin
					write_reg(CFG_SLOT_LIMIT, 16); write_reg(CFG_COMPACT_ON, 1);
					write_reg(CFG_COMPACT_IVL, 0); write_reg(CFG_DEDUP_ON, 1);
					write_reg(CFG_DEDUP_IVL, 0);
				end
				1: begin
					write_reg(CFG_SLOT_LIMIT, 127); write_reg(CFG_COMPACT_IVL, 50);
					write_reg(CFG_DEDUP_IVL, 65535);
				end
				2: begin
					write_reg(CFG_SLOT_LIMIT, 64); write_reg(CFG_COMPACT_ON, 0);
					write_reg(CFG_DEDUP_ON, 0);
				end
				3: begin
					write_reg(CFG_SLOT_LIMIT, 8); write_reg(CFG_COMPACT_ON, 1);
					write_reg(CFG_COMPACT_IVL, 65535); write_reg(CFG_DEDUP_ON, 1);
					write_reg(CFG_DEDUP_IVL, 30);
				end
				4: begin
					write_reg(CFG_SLOT_LIMIT, 65); write_reg(CFG_COMPACT_IVL, 20);
				end
				default: begin
					write_reg(CFG_SLOT_LIMIT, 32); quiet = 1;
				end
			endcase
			for (int i = 0; i < 270; i++) pending_reqs.push_back(rand_req());
			drain();
		end

		if (errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end
endmodule

### files.f
rtl/core/ptd_pkg.sv
rtl/core/ptd_if.sv
rtl/core/ptd_ram.sv
rtl/core/ptd_dp.sv
rtl/core/ptd_ctrl.sv
rtl/core/periodic_task_dispatcher.sv
bench/testbench.sv
